>>> src/pvc_pkg.sv
// pvc_pkg: word types, operation codes and verdict codes for the verdict cache.
// No dependencies; imported by probe_verdict_cache_top and pvc_checker.
package pvc_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned MODIFIER_W = 64;
  localparam int unsigned VERDICT_W  = 2;
  localparam int unsigned COUNT_W    = 5;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_LOOKUP     = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RECORD     = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_INVALIDATE = 2'd2;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN  = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_OK       = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_REJECTED = 2'd2;

  // Removal count saturates here
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  typedef struct packed {
    logic [OPCODE_W-1:0]   opcode;
    logic [ID_W-1:0]       crtc_id;
    logic [ID_W-1:0]       plane_num;
    logic [ID_W-1:0]       fourcc_code;
    logic [MODIFIER_W-1:0] modifier_value;
    logic                  probe_ok;
  } pvc_in_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic                 dropped_full;
    logic [COUNT_W-1:0]   removed_count;
  } pvc_out_t;

endpackage

>>> src/probe_verdict_cache_top.sv
// probe_verdict_cache_top: fully associative cache of probe verdicts, one
// operation per word. Depends on pvc_pkg for word types and codes.
//
//  channel | direction | handshake         | word type
//  --------+-----------+-------------------+------------------
//  in_     | into      | in_valid/in_stall | pvc_pkg::pvc_in_t
//  out_    | out of    | out_valid/out_stall| pvc_pkg::pvc_out_t
//
// Flow: one operation is taken every clock while out_stall stays low; its
// result word passes the input register, then the result register. The rate
// is set by the single pass of key compare, free-slot pick and table write
// that sits between those two registers.
// Reset: synchronous, active low; clears the entry valid bits and both valid
// flags at once, so no clearing pass follows. Key and verdict stores hold
// whatever they held until an entry is filled.
// Stalls: out_stall holds the result register; the input register then holds
// too and in_stall rises, so nothing is lost while the table stays unchanged.
module probe_verdict_cache_top #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pvc_pkg::pvc_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output pvc_pkg::pvc_out_t out_word
);
  import pvc_pkg::*;

  // Enough bits to count every entry removed in one pass
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Input register
  logic    s1_valid_r, s1_valid_nxt;
  pvc_in_t s1_word_r;

  // Result register
  logic     out_valid_r, out_valid_nxt;
  pvc_out_t out_word_r, out_word_nxt;

  // Table storage: valid bits are reset, the rest is filled on record
  logic [TABLE_ENTRIES-1:0] entry_valid_r, entry_valid_nxt;
  logic [ID_W-1:0]          entry_crtc_r     [TABLE_ENTRIES];
  logic [ID_W-1:0]          entry_plane_r    [TABLE_ENTRIES];
  logic [ID_W-1:0]          entry_fourcc_r   [TABLE_ENTRIES];
  logic [MODIFIER_W-1:0]    entry_modifier_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] entry_ok_r;

  // Handshake
  logic in_fire, advance, s1_fire;

  // Per-entry match and select vectors
  logic [TABLE_ENTRIES-1:0] key_hit, plane_hit, free_oh, fill_oh, upd_oh;
  logic                     any_hit, any_free;
  logic                     do_lookup, do_record, do_invalidate, new_rec;
  logic [CNT_W-1:0]         cnt_sum;
  logic [COUNT_W-1:0]       removed;

  // The result register frees when empty or when its word is taken.
  assign advance  = ~out_valid_r | ~out_stall;
  assign s1_fire  = s1_valid_r & advance;
  assign in_stall = s1_valid_r & ~advance;
  assign in_fire  = in_valid & ~in_stall;

  assign do_lookup     = s1_word_r.opcode == OP_LOOKUP;
  assign do_record     = s1_word_r.opcode == OP_RECORD;
  assign do_invalidate = s1_word_r.opcode == OP_INVALIDATE;

  // Compare every entry against the key held in the input register.
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      key_hit[i]   = entry_valid_r[i]
                   && entry_crtc_r[i]     == s1_word_r.crtc_id
                   && entry_plane_r[i]    == s1_word_r.plane_num
                   && entry_fourcc_r[i]   == s1_word_r.fourcc_code
                   && entry_modifier_r[i] == s1_word_r.modifier_value;
      plane_hit[i] = entry_valid_r[i] && entry_plane_r[i] == s1_word_r.plane_num;
    end
  end

  // Keys are unique, so at most one entry hits.
  assign any_hit  = |key_hit;
  // Lowest clear valid bit: adding one and masking with the inverted bits isolates it.
  assign free_oh  = ~entry_valid_r & (entry_valid_r + TABLE_ENTRIES'(1));
  assign any_free = ~&entry_valid_r;
  assign new_rec  = s1_fire & do_record & ~any_hit;
  assign fill_oh  = new_rec ? free_oh : '0;
  assign upd_oh   = (s1_fire & do_record & any_hit) ? key_hit : '0;

  // Count removals, then saturate to the result field.
  always_comb begin
    cnt_sum = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (plane_hit[i]) begin
        cnt_sum = cnt_sum + CNT_W'(1);
      end
    end
    if (32'(cnt_sum) > 32'(COUNT_MAX)) begin
      removed = COUNT_MAX;
    end else begin
      removed = COUNT_W'(cnt_sum);
    end
  end

  // Valid bits: set on fill, drop on invalidate of the plane.
  always_comb begin
    entry_valid_nxt = entry_valid_r | fill_oh;
    if (s1_fire && do_invalidate) begin
      entry_valid_nxt = entry_valid_r & ~plane_hit;
    end
  end

  // Result word; every field stays zero for an unused opcode.
  always_comb begin
    out_word_nxt = '0;
    if (do_lookup && any_hit) begin
      out_word_nxt.verdict = |(key_hit & entry_ok_r) ? VERDICT_OK : VERDICT_REJECTED;
    end
    if (do_record && !any_hit && !any_free) begin
      out_word_nxt.dropped_full = 1'b1;
    end
    if (do_invalidate) begin
      out_word_nxt.removed_count = removed;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      entry_valid_r <= '0;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      entry_valid_r <= entry_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r <= in_word;
    end
    if (s1_fire) begin
      out_word_r <= out_word_nxt;
    end
  end

  // Table stores: fill a new key, or rewrite the verdict of a known one.
  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (fill_oh[i]) begin
        entry_crtc_r[i]     <= s1_word_r.crtc_id;
        entry_plane_r[i]    <= s1_word_r.plane_num;
        entry_fourcc_r[i]   <= s1_word_r.fourcc_code;
        entry_modifier_r[i] <= s1_word_r.modifier_value;
      end
      if (fill_oh[i] || upd_oh[i]) begin
        entry_ok_r[i] <= s1_word_r.probe_ok;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> src/pvc_checker.sv
// pvc_checker: port-level checks on the verdict cache result channel.
// Depends on pvc_pkg; bound to probe_verdict_cache_top at the end of this file.
module pvc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input pvc_pkg::pvc_out_t out_word
);
  import pvc_pkg::*;

  // Hold a stalled word in place.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result valid dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word))
    else $error("result word changed while stalled");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.verdict == VERDICT_UNKNOWN
               || out_word.verdict == VERDICT_OK
               || out_word.verdict == VERDICT_REJECTED)
    else $error("verdict holds an unused code");

  a_drop_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.dropped_full |->
      out_word.verdict == VERDICT_UNKNOWN && out_word.removed_count == '0)
    else $error("dropped record carries other result fields");

  a_remove_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.removed_count != '0 |->
      out_word.verdict == VERDICT_UNKNOWN && !out_word.dropped_full)
    else $error("invalidate result carries other result fields");

endmodule

bind probe_verdict_cache_top pvc_checker u_pvc_checker (.*);

>>> tb/sv/tb_probe_verdict_cache_top.sv
// Self-checking testbench for probe_verdict_cache_top: drives lookup, record and
// invalidate words under random idling and compares every result word against a
// behavioural copy of the verdict table. Depends on pvc_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_probe_verdict_cache_top;
  import pvc_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned KEY_POOL      = 24;   // more keys than slots, so the table fills
  localparam int unsigned PLANE_POOL    = 4;
  localparam int unsigned CHUNK_WORDS   = 50;
  localparam int unsigned RANDOM_WORDS  = 574;  // per phase
  localparam int unsigned LIMIT_CYCLES  = 200000;
  localparam int unsigned TAIL_CYCLES   = 8;

  // The one opcode the block does not use
  localparam logic [OPCODE_W-1:0] OP_UNUSED  = 2'd3;
  localparam logic [ID_W-1:0]     FILL_PLANE = 32'h8000_0001;

  typedef struct packed {
    logic [ID_W-1:0]       crtc;
    logic [ID_W-1:0]       plane;
    logic [ID_W-1:0]       fourcc;
    logic [MODIFIER_W-1:0] modifier;
  } cache_key_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  pvc_in_t  in_word = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pvc_out_t out_word;

  // Behavioural copy of the verdict table
  logic       shadow_valid [TABLE_ENTRIES];
  cache_key_t shadow_key   [TABLE_ENTRIES];
  logic       shadow_ok    [TABLE_ENTRIES];

  pvc_out_t    pending_results[$];
  pvc_out_t    expected_word;
  cache_key_t  key_pool   [KEY_POOL];
  logic [ID_W-1:0] plane_pool [PLANE_POOL];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned err_count     = 0;
  int unsigned cycle_count   = 0;

  probe_verdict_cache_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run, even with the receiver stalling
  // at the highest stall rate that the phases below set.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Apply one accepted word to the shadow table and return the result it must
  // produce. Keys are unique in the table, so the first hit is the only hit.
  function automatic pvc_out_t apply_to_table(input pvc_in_t w);
    pvc_out_t   res;
    cache_key_t k;
    int         hit;
    int         slot;
    res  = '0;
    k    = {w.crtc_id, w.plane_num, w.fourcc_code, w.modifier_value};
    hit  = -1;
    slot = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0 && shadow_valid[i] && shadow_key[i] == k) hit = i;
      if (slot < 0 && !shadow_valid[i]) slot = i;
    end
    case (w.opcode)
      OP_LOOKUP: begin
        if (hit >= 0) res.verdict = shadow_ok[hit] ? VERDICT_OK : VERDICT_REJECTED;
      end
      OP_RECORD: begin
        if (hit >= 0) begin
          // Known key: only the verdict moves
          shadow_ok[hit] = w.probe_ok;
        end else if (slot < 0) begin
          // Table full: drop the record and flag it
          res.dropped_full = 1'b1;
        end else begin
          // Fill the lowest free slot
          shadow_valid[slot] = 1'b1;
          shadow_key[slot]   = k;
          shadow_ok[slot]    = w.probe_ok;
        end
      end
      OP_INVALIDATE: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (shadow_valid[i] && shadow_key[i].plane == w.plane_num) begin
            shadow_valid[i] = 1'b0;
            if (res.removed_count != COUNT_MAX) res.removed_count++;
          end
        end
      end
      default: begin
        // Unused opcode: no change, all-zero result
      end
    endcase
    return res;
  endfunction

  function automatic pvc_in_t make_word(input logic [OPCODE_W-1:0] op,
                                        input cache_key_t k, input logic ok);
    pvc_in_t w;
    w.opcode         = op;
    w.crtc_id        = k.crtc;
    w.plane_num      = k.plane;
    w.fourcc_code    = k.fourcc;
    w.modifier_value = k.modifier;
    w.probe_ok       = ok;
    return w;
  endfunction

  // Mostly keys from the pool so lookups hit and records update; some keys one
  // bit away from a pool key to exercise every compare bit; some pure noise.
  function automatic cache_key_t pick_key();
    cache_key_t                    k;
    logic [$bits(cache_key_t)-1:0] flip;
    int unsigned                   r;
    r = $urandom_range(99);
    k = key_pool[$urandom_range(KEY_POOL - 1)];
    if (r >= 90) begin
      k = {$urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (r >= 80) begin
      flip = '0;
      flip[$urandom_range($bits(cache_key_t) - 1)] = 1'b1;
      k = k ^ flip;
    end
    return k;
  endfunction

  function automatic pvc_in_t random_word(input int unsigned inval_pct);
    logic [OPCODE_W-1:0] op;
    int unsigned         r;
    r = $urandom_range(99);
    if (r < inval_pct) op = OP_INVALIDATE;
    else if (r < inval_pct + 3) op = OP_UNUSED;
    else op = $urandom_range(1) ? OP_RECORD : OP_LOOKUP;
    return make_word(op, pick_key(), 1'($urandom_range(1)));
  endfunction

  // Offer one word, idling at random beforehand; predict its result once taken.
  task automatic issue_word(input pvc_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_word  <= make_word(OP_UNUSED, {$urandom, $urandom, $urandom, $urandom, $urandom},
                            1'($urandom_range(1)));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    pending_results.insert(pending_results.size(), apply_to_table(w));
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Extreme keys, both verdicts, update of a known key, near miss, unused opcode.
  task automatic test_known_keys();
    cache_key_t zero_key;
    cache_key_t ones_key;
    cache_key_t near_key;
    zero_key = '0;
    ones_key = '1;
    near_key = ones_key;
    near_key.modifier[0] = 1'b0;
    issue_word(make_word(OP_LOOKUP, zero_key, 1'b0));     // empty table: unknown
    issue_word(make_word(OP_RECORD, zero_key, 1'b1));
    issue_word(make_word(OP_RECORD, ones_key, 1'b0));
    issue_word(make_word(OP_LOOKUP, ones_key, 1'b0));     // rejected
    issue_word(make_word(OP_RECORD, ones_key, 1'b1));     // update in place
    issue_word(make_word(OP_LOOKUP, near_key, 1'b1));     // one bit off: unknown
    issue_word(make_word(OP_UNUSED, ones_key, 1'b0));     // must change nothing
    issue_word(make_word(OP_LOOKUP, ones_key, 1'b0));     // still ok
    issue_word(make_word(OP_INVALIDATE, ones_key, 1'b1)); // removes one
  endtask

  // Fill every slot, overflow it, update a key while full, then clear one plane.
  task automatic test_table_full();
    cache_key_t k;
    for (int i = 1; i < TABLE_ENTRIES; i++) begin
      k = {$urandom, FILL_PLANE, 32'(i), $urandom, $urandom};
      issue_word(make_word(OP_RECORD, k, 1'($urandom_range(1))));
    end
    k = {$urandom, ~FILL_PLANE, $urandom, $urandom, $urandom};
    issue_word(make_word(OP_RECORD, k, 1'b1));            // no slot: dropped
    issue_word(make_word(OP_RECORD, '0, 1'b0));           // known key, table full
    issue_word(make_word(OP_LOOKUP, '0, 1'b1));           // rejected now
    k.plane = FILL_PLANE;
    issue_word(make_word(OP_INVALIDATE, k, 1'b0));        // removes the fill entries
    issue_word(make_word(OP_INVALIDATE, k, 1'b1));        // nothing left to remove
  endtask

  // Random traffic in chunks; the invalidate rate changes per chunk so the
  // table swings between nearly empty and full.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned inval_pct;
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(2))
        0:       inval_pct = 1;
        1:       inval_pct = 5;
        default: inval_pct = 15;
      endcase
      for (int i = 0; i < CHUNK_WORDS && sent < count; i++) begin
        issue_word(random_word(inval_pct));
        sent++;
      end
    end
  endtask

  // Drive the receiver's stall and check each result word as it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word %h with nothing expected", out_word);
        err_count++;
      end else begin
        expected_word = pending_results.pop_front();
        if (out_word.verdict !== expected_word.verdict) begin
          $error("verdict: expected %0d, got %0d", expected_word.verdict, out_word.verdict);
          err_count++;
        end
        if (out_word.dropped_full !== expected_word.dropped_full) begin
          $error("dropped_full: expected %0d, got %0d",
                 expected_word.dropped_full, out_word.dropped_full);
          err_count++;
        end
        if (out_word.removed_count !== expected_word.removed_count) begin
          $error("removed_count: expected %0d, got %0d",
                 expected_word.removed_count, out_word.removed_count);
          err_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_ok[i]    = 1'b0;
    end
    for (int i = 0; i < PLANE_POOL; i++) plane_pool[i] = $urandom;
    for (int i = 0; i < KEY_POOL; i++) begin
      key_pool[i] = {$urandom, plane_pool[i % PLANE_POOL], $urandom, $urandom, $urandom};
    end

    // Hold reset low at the start, then release
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles now and then, receiver stalls most of the time
    send_idle_pct = 17;
    stall_pct     = 77;
    test_known_keys();
    test_table_full();
    test_random_traffic(RANDOM_WORDS);
    drain();

    // Phase two: the other way round
    send_idle_pct = 77;
    stall_pct     = 17;
    test_random_traffic(RANDOM_WORDS);
    drain();

    // Phase three: back to back in both directions
    send_idle_pct = 0;
    stall_pct     = 0;
    test_random_traffic(RANDOM_WORDS);
    drain();

    // Let the pipeline settle so any stray result word is caught
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
